/* src/anfs_pkg.sv */
// Shared types and constants of the Annex B NAL fragment splitter.
`default_nettype none
package anfs_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1048576;
  localparam int unsigned MAX_FRAGMENTS   = 32;

  localparam int unsigned OFF_W   = 20;
  localparam int unsigned LEN_W   = 21;
  localparam int unsigned POS_W   = 21;
  localparam int unsigned FOUND_W = 6;

  localparam logic [7:0] START_BYTE = 8'h01;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_START = 2'd1,
    STATUS_OVERLONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [OFF_W-1:0] payload_offset;
    logic [LEN_W-1:0] payload_length;
    status_e          status;
    logic             last_of_frame;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage
`default_nettype wire

/* src/anfs_in_if.sv */
// Input item channel: one frame byte with its frame end mark.
`default_nettype none
interface anfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface
`default_nettype wire

/* src/anfs_out_if.sv */
// Result item channel: payload offset, length, status and last mark.
`default_nettype none
interface anfs_out_if;
  logic                            valid;
  logic                            ready;
  logic [anfs_pkg::OFF_W-1:0]      payload_offset;
  logic [anfs_pkg::LEN_W-1:0]      payload_length;
  logic [1:0]                      status;
  logic                            last_of_frame;

  modport source (
    output valid, output payload_offset, output payload_length,
    output status, output last_of_frame, input ready
  );
  modport sink (
    input valid, input payload_offset, input payload_length,
    input status, input last_of_frame, output ready
  );
endinterface
`default_nettype wire

/* src/anfs_scan.sv */
// Start code scanner state and per-byte result generation.
`default_nettype none
module anfs_scan (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                frame_end_i,
  output anfs_pkg::push_t          push_o
);

  localparam logic [anfs_pkg::POS_W-1:0] PosMax =
    anfs_pkg::POS_W'(anfs_pkg::MAX_FRAME_BYTES);
  localparam logic [anfs_pkg::FOUND_W-1:0] FoundMax =
    anfs_pkg::FOUND_W'(anfs_pkg::MAX_FRAGMENTS);

  logic [anfs_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [1:0]                   zrun_q, zrun_d;
  logic [anfs_pkg::OFF_W-1:0]   cstart_q, cstart_d;
  logic [2:0]                   clen_q, clen_d;
  logic [1:0]                   cdown_q, cdown_d;
  logic [anfs_pkg::POS_W-1:0]   open_q, open_d;
  logic [anfs_pkg::FOUND_W-1:0] found_q, found_d;

  anfs_pkg::result_t conf_res, end_res;
  logic              conf_hit;

  always_comb begin
    pos_d    = pos_q;
    zrun_d   = zrun_q;
    cstart_d = cstart_q;
    clen_d   = clen_q;
    cdown_d  = cdown_q;
    open_d   = open_q;
    found_d  = found_q;
    conf_hit = 1'b0;
    conf_res = '0;
    end_res  = '0;
    push_o   = '0;

    if (accept_i) begin
      if (pos_q < PosMax) begin
        if (clen_d != 3'd0) begin
          if (cdown_d != 2'd0) begin
            cdown_d = cdown_d - 2'd1;
          end
          if (cdown_d == 2'd0) begin
            if (found_d != '0) begin
              conf_hit                = 1'b1;
              conf_res.payload_offset = open_d[anfs_pkg::OFF_W-1:0];
              conf_res.payload_length = {1'b0, cstart_d} - open_d;
              conf_res.status         = anfs_pkg::STATUS_OK;
            end
            open_d  = {1'b0, cstart_d} + anfs_pkg::POS_W'(clen_d);
            found_d = found_d + 1'b1;
            clen_d  = 3'd0;
          end
        end
        if (data_byte_i == anfs_pkg::START_BYTE && zrun_q >= 2'd2 &&
            clen_d == 3'd0 && found_d < FoundMax) begin
          if (zrun_q == 2'd3) begin
            cstart_d = pos_q[anfs_pkg::OFF_W-1:0] - anfs_pkg::OFF_W'(3);
            clen_d   = 3'd4;
            cdown_d  = 2'd1;
          end else begin
            cstart_d = pos_q[anfs_pkg::OFF_W-1:0] - anfs_pkg::OFF_W'(2);
            clen_d   = 3'd3;
            cdown_d  = 2'd2;
          end
        end
        if (data_byte_i == 8'h00) begin
          zrun_d = (zrun_q == 2'd3) ? 2'd3 : zrun_q + 2'd1;
        end else begin
          zrun_d = 2'd0;
        end
        pos_d = pos_q + 1'b1;
      end else begin
        clen_d  = 3'd0;
        cdown_d = 2'd0;
        pos_d   = PosMax + 1'b1;
      end

      if (frame_end_i) begin
        end_res.last_of_frame = 1'b1;
        if (pos_d > PosMax) begin
          end_res.status = anfs_pkg::STATUS_OVERLONG;
        end else if (found_d == '0) begin
          end_res.status = anfs_pkg::STATUS_NO_START;
        end else begin
          end_res.status         = anfs_pkg::STATUS_OK;
          end_res.payload_offset = open_d[anfs_pkg::OFF_W-1:0];
          end_res.payload_length = pos_d - open_d;
        end
        pos_d    = '0;
        zrun_d   = '0;
        cstart_d = '0;
        clen_d   = '0;
        cdown_d  = '0;
        open_d   = '0;
        found_d  = '0;
      end

      if (conf_hit) begin
        push_o.first  = conf_res;
        push_o.second = end_res;
        push_o.count  = frame_end_i ? 2'd2 : 2'd1;
      end else begin
        push_o.first  = end_res;
        push_o.count  = frame_end_i ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      zrun_q   <= '0;
      cstart_q <= '0;
      clen_q   <= '0;
      cdown_q  <= '0;
      open_q   <= '0;
      found_q  <= '0;
    end else begin
      pos_q    <= pos_d;
      zrun_q   <= zrun_d;
      cstart_q <= cstart_d;
      clen_q   <= clen_d;
      cdown_q  <= cdown_d;
      open_q   <= open_d;
      found_q  <= found_d;
    end
  end

endmodule
`default_nettype wire

/* src/anfs_fifo.sv */
// Result queue taking up to two items per cycle and giving one.
`default_nettype none
module anfs_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire anfs_pkg::push_t    push_i,
  output logic                    room_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output anfs_pkg::result_t       data_o
);

  anfs_pkg::result_t                 ent_q [anfs_pkg::FIFO_DEPTH];
  logic [anfs_pkg::FIFO_AW-1:0]      wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [anfs_pkg::FIFO_CW-1:0]      cnt_q, cnt_d;
  logic                              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rd_q];
  assign room_o  = (cnt_q <= anfs_pkg::FIFO_CW'(anfs_pkg::FIFO_DEPTH - 2));
  assign wr_next = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + anfs_pkg::FIFO_AW'(push_i.count);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + anfs_pkg::FIFO_CW'(push_i.count) - anfs_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      ent_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      ent_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* src/annexb_nal_fragment_splitter.sv */
// Top level of the Annex B NAL fragment splitter.
//
// The in_i channel takes one frame byte per item, with frame_end set on the
// last byte of a frame. The out_o channel gives one item per NAL payload:
// offset just past its start code and its length; a frame without a start
// code or longer than the frame bound ends with a single status item.
// A payload item leaves once the next start code is confirmed, four bytes
// after its first byte; the last payload item leaves at frame end.
// A result item is registered in the result queue before it reaches out_o.
// The block takes one byte per cycle while in_i.ready is high; a byte that
// causes two result items writes both into the queue together, and the
// four-entry result queue drains one item per cycle while out_o.ready is high.
// in_i.ready drops while the queue holds more than two items, so a stalled
// receiver holds every result and back pressure reaches the byte source.
// Reset clears the scanner state and empties the queue; the block then
// waits for the first byte of a new frame.
`default_nettype none
module annexb_nal_fragment_splitter (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  anfs_in_if.sink     in_i,
  anfs_out_if.source  out_o
);

  anfs_pkg::push_t   push;
  anfs_pkg::result_t head;
  logic              room;
  logic              accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  anfs_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .frame_end_i (in_i.frame_end),
    .push_o      (push)
  );

  anfs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head)
  );

  assign out_o.payload_offset = head.payload_offset;
  assign out_o.payload_length = head.payload_length;
  assign out_o.status         = head.status;
  assign out_o.last_of_frame  = head.last_of_frame;

endmodule
`default_nettype wire

/* tb/sv/annexb_nal_fragment_splitter_test.sv */
// Self-checking testbench: Annex B byte streams in, NAL payload items checked against a model.
module annexb_nal_fragment_splitter_test;
  import anfs_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       wait_idle;
    logic [7:0] gap;
  } stream_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  always #6 clk_i = ~clk_i;

  anfs_in_if  byte_ch ();
  anfs_out_if frag_ch ();

  annexb_nal_fragment_splitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (frag_ch)
  );

  stream_byte_t bytes_to_send[$];
  result_t      fragments_due[$];

  int unsigned mismatches = 0;
  int unsigned frames_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned no_start_seen = 0;
  int unsigned holds_done = 0;
  logic        gaps_on = 1'b1;
  logic        drain_before_next = 1'b0;

  // Scanner state, cleared after every frame end.
  logic [POS_W-1:0]   scan_pos     = '0;
  logic [1:0]         zeros_seen   = '0;
  logic [OFF_W-1:0]   code_start   = '0;
  logic [2:0]         code_len     = '0;
  logic [1:0]         confirm_left = '0;
  logic [POS_W-1:0]   open_off     = '0;
  logic [FOUND_W-1:0] codes_found  = '0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (scan_pos < POS_W'(MAX_FRAME_BYTES)) begin
      if (code_len != 3'd0) begin
        if (confirm_left != 2'd0) confirm_left--;
        if (confirm_left == 2'd0) begin
          if (codes_found != '0) begin
            r.payload_offset = open_off[OFF_W-1:0];
            r.payload_length = {1'b0, code_start} - open_off;
            r.status = STATUS_OK;
            r.last_of_frame = 1'b0;
            fragments_due = {fragments_due, r};
          end
          open_off = {1'b0, code_start} + POS_W'(code_len);
          codes_found++;
          code_len = 3'd0;
        end
      end
      if (b == START_BYTE && zeros_seen >= 2'd2 && code_len == 3'd0 &&
          codes_found < FOUND_W'(MAX_FRAGMENTS)) begin
        if (zeros_seen == 2'd3) begin
          code_start = OFF_W'(scan_pos - POS_W'(3));
          code_len = 3'd4;
          confirm_left = 2'd1;
        end else begin
          code_start = OFF_W'(scan_pos - POS_W'(2));
          code_len = 3'd3;
          confirm_left = 2'd2;
        end
      end
      if (b != 8'h00) zeros_seen = 2'd0;
      else if (zeros_seen != 2'd3) zeros_seen = zeros_seen + 2'd1;
      scan_pos++;
    end else begin
      code_len = 3'd0;
      confirm_left = 2'd0;
      scan_pos = POS_W'(MAX_FRAME_BYTES + 1);
    end
    if (last) begin
      r.payload_offset = '0;
      r.payload_length = '0;
      r.last_of_frame = 1'b1;
      if (scan_pos > POS_W'(MAX_FRAME_BYTES)) begin
        r.status = STATUS_OVERLONG;
      end else if (codes_found == '0) begin
        r.status = STATUS_NO_START;
      end else begin
        r.status = STATUS_OK;
        r.payload_offset = open_off[OFF_W-1:0];
        r.payload_length = scan_pos - open_off;
      end
      fragments_due = {fragments_due, r};
      scan_pos = '0;
      zeros_seen = '0;
      code_start = '0;
      code_len = '0;
      confirm_left = '0;
      open_off = '0;
      codes_found = '0;
    end
  endtask

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 64);
  endfunction

  function automatic logic [7:0] noisy_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'h00;
    if (r < 35) return START_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_byte(input logic [7:0] v, input logic last);
    stream_byte_t s;
    s.value = v;
    s.last = last;
    s.wait_idle = drain_before_next;
    s.gap = (gaps_on && $urandom_range(0, 99) >= 55) ? 8'(idle_span()) : 8'd0;
    drain_before_next = 1'b0;
    bytes_to_send = {bytes_to_send, s};
  endtask

  task automatic queue_frame(input logic [7:0] frame_q[$]);
    foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
    frames_queued++;
  endtask

  // Byte source: offer the head of the queue after its gap, optionally once all results are in.
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    logic offer;
    stream_byte_t head;
    int unsigned gap_left;
    logic gap_served;
    if (!rst_ni) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data_byte <= 8'h00;
      byte_ch.frame_end <= 1'b0;
      gap_left = 0;
      gap_served = 1'b0;
    end else begin
      offer = byte_ch.valid;
      if (byte_ch.valid && byte_ch.ready) begin
        scan_byte(byte_ch.data_byte, byte_ch.frame_end);
        bytes_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (bytes_to_send.size() != 0) begin
          head = bytes_to_send[0];
          if (!gap_served && head.gap != 8'd0) begin
            gap_left = head.gap - 1;
            gap_served = 1'b1;
          end else if (!head.wait_idle || fragments_due.size() == 0) begin
            head = bytes_to_send.pop_front();
            byte_ch.data_byte <= head.value;
            byte_ch.frame_end <= head.last;
            gap_served = 1'b0;
            offer = 1'b1;
          end
        end
      end
      byte_ch.valid <= offer;
    end
  end

  // Result sink: random stalls in changing stretches, plus long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin : drive_ready
    int unsigned stall_left;
    int unsigned mode_left;
    int unsigned hold_mark;
    logic stalls_on;
    if (!rst_ni) begin
      frag_ch.ready <= 1'b0;
      stall_left = 0;
      mode_left = 0;
      hold_mark = 10;
      stalls_on = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stalls_on = ($urandom_range(0, 3) != 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left == 0 && results_seen >= hold_mark) begin
        stall_left = 180;
        hold_mark += 900;
        holds_done++;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 99) < 30) begin
        stall_left = idle_span();
      end
      frag_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    result_t want;
    if (!rst_ni) begin
      results_seen <= 0;
    end else if (frag_ch.valid && frag_ch.ready) begin
      results_seen <= results_seen + 1;
      if (fragments_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item offset %0d length %0d status %0d last %0b",
          frag_ch.payload_offset, frag_ch.payload_length, frag_ch.status,
          frag_ch.last_of_frame));
      end else begin
        want = fragments_due.pop_front();
        if (frag_ch.payload_offset != want.payload_offset)
          report_mismatch($sformatf("payload_offset %0d, want %0d",
            frag_ch.payload_offset, want.payload_offset));
        if (frag_ch.payload_length != want.payload_length)
          report_mismatch($sformatf("payload_length %0d, want %0d",
            frag_ch.payload_length, want.payload_length));
        if (frag_ch.status != want.status)
          report_mismatch($sformatf("status %0d, want %0d", frag_ch.status, want.status));
        if (frag_ch.last_of_frame != want.last_of_frame)
          report_mismatch($sformatf("last_of_frame %0b, want %0b",
            frag_ch.last_of_frame, want.last_of_frame));
        if (want.status == STATUS_NO_START) no_start_seen++;
      end
    end
  end

  initial begin
    logic [7:0] frame[$];
    int unsigned codes;
    int unsigned n;
    int unsigned random_bytes;
    int unsigned waited;
    rst_ni = 1'b0;

    frame = '{8'h00, 8'h00, START_BYTE, 8'hFF, 8'h00};
    queue_frame(frame);
    frame = '{8'h00, 8'h00, 8'h00, START_BYTE, 8'h65, 8'h88, 8'h00, 8'h00, START_BYTE,
              8'h41, 8'h9A, 8'h7F};
    queue_frame(frame);
    frame = '{8'h34, 8'h00, 8'h00, START_BYTE, 8'h09};
    queue_frame(frame);
    frame = '{8'hFF};
    queue_frame(frame);
    frame = '{8'h00};
    queue_frame(frame);
    frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, START_BYTE, 8'h80, 8'h80, 8'h80, 8'h80};
    queue_frame(frame);
    frame = '{START_BYTE, 8'h00, START_BYTE, 8'h00, 8'h00, START_BYTE, 8'h00, 8'h00,
              START_BYTE, 8'hAA, 8'hBB, 8'hCC, 8'hDD};
    queue_frame(frame);

    // More start codes than the fragment limit; the last payload runs to frame end.
    drain_before_next = 1'b1;
    frame.delete();
    for (int unsigned k = 0; k < 36; k++) begin
      frame = {frame, 8'h00};
      frame = {frame, 8'h00};
      frame = {frame, START_BYTE};
      frame = {frame, 8'(8'h40 + k)};
    end
    frame = {frame, 8'hAA};
    queue_frame(frame);

    gaps_on = 1'b1;
    drain_before_next = 1'b1;
    random_bytes = 0;
    while (random_bytes < 1460) begin
      if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
      if (frames_queued % 40 == 0) drain_before_next = 1'b1;
      frame.delete();
      if ($urandom_range(0, 99) < 75) begin
        codes = ($urandom_range(0, 99) < 4) ? $urandom_range(30, 36) : $urandom_range(1, 4);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) frame = {frame, noisy_byte()};
        repeat (codes) begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 2;
          repeat (n) frame = {frame, 8'h00};
          frame = {frame, START_BYTE};
          n = (codes > 8) ? $urandom_range(0, 3) : $urandom_range(0, 10);
          repeat (n) frame = {frame, 8'($urandom_range(0, 255))};
        end
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(1, 4);
          repeat (n) if (frame.size() > 1) frame.delete(frame.size() - 1);
        end
      end else begin
        n = $urandom_range(1, 16);
        repeat (n) frame = {frame, noisy_byte()};
      end
      random_bytes += frame.size();
      queue_frame(frame);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i); while (bytes_to_send.size() != 0 || byte_ch.valid);
    waited = 0;
    while (fragments_due.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
    if (fragments_due.size() != 0)
      report_mismatch($sformatf("%0d expected items never arrived", fragments_due.size()));

    $display("ran %0d frames, %0d bytes, %0d result items (%0d without start code)",
      frames_queued, bytes_accepted, results_seen, no_start_seen);
    $display("receiver long hold-offs: %0d, mismatches: %0d", holds_done, mismatches);
    if (mismatches == 0) begin
      $display("annexb_nal_fragment_splitter verification clean");
    end else begin
      $display("annexb_nal_fragment_splitter verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("annexb_nal_fragment_splitter verification failed");
    $finish;
  end

endmodule

/* sim.f */
src/anfs_pkg.sv
src/anfs_in_if.sv
src/anfs_out_if.sv
src/anfs_scan.sv
src/anfs_fifo.sv
src/annexb_nal_fragment_splitter.sv
tb/sv/annexb_nal_fragment_splitter_test.sv
